// File: rtl/core/sequential_list_engine_assert.svh
// Assertion macros for the sequential list engine checker
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// checked outside reset
`define SLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sle_pkg.sv
// Shared constants, codes and types for the sequential list engine
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int DATA_W           = 32;
  localparam int POS_W            = 9;
  localparam int CMD_W            = 3;
  localparam int STATUS_W         = 2;
  localparam int IDX_W            = 16;
  localparam int DEFAULT_CAPACITY = 256;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRED   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_ROT  = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] slot;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/sle_cell.sv
// One list slot: holds an entry and moves it to or from its neighbours
`timescale 1ns / 1ps
`default_nettype none

module sle_cell
  import sle_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] ins_value,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  output logic      [DATA_W-1:0] entry
);

  localparam logic [IDX_W-1:0] SLOT_ID = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ROT: begin
        entry <= right;
      end
      OP_INS: begin
        if (SLOT_ID > ctrl.slot) begin
          entry <= left;
        end else if (SLOT_ID == ctrl.slot) begin
          entry <= ins_value;
        end
      end
      OP_DEL: begin
        if (SLOT_ID >= ctrl.slot) begin
          entry <= right;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/sle_chain.sv
// Ring of list cells; slot zero is the head seen by the controller
`timescale 1ns / 1ps
`default_nettype none

module sle_chain
  import sle_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] ins_value,
  output logic      [DATA_W-1:0] head
);

  logic [DATA_W-1:0] entry [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int LEFT_K  = (k == 0) ? 0 : k - 1;
    localparam int RIGHT_K = (k == CAPACITY - 1) ? 0 : k + 1;

    sle_cell #(
      .INDEX(k)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_value(ins_value),
      .left     (entry[LEFT_K]),
      .right    (entry[RIGHT_K]),
      .entry    (entry[k])
    );
  end

  assign head = entry[0];

endmodule

`default_nettype wire

// File: rtl/core/sequential_list_engine.sv
// Top level of the sequential list engine: command control over a ring of cells
//
// Input stream s_*: one word per command (insert, delete, get, locate,
// predecessor, successor, or clear via the clear flag). Output stream m_*:
// exactly one word per command with status, value, found position and
// the list length after the command.
// One command is handled at a time. Clear, unused codes, rejected
// positions and full inserts go from decode straight to the done state;
// insert passes through the shift state. Delete, get, locate, predecessor
// and successor rotate the whole ring of CAPACITY cells once through the
// head, one cell per cycle; delete then does a closing shift.
// s_tready is high only while no command is in progress; the next command
// may be taken while the previous result still waits in the output
// register, and its result is held back until that word is taken.
// Reset empties the list and drops any pending result; cell contents are
// not cleared and never read beyond the current length.
// A stalled m_tready holds the output word unchanged.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [8:0] position, [40:9] value, rest zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [2:0] cmd, [3] clear_request
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] result_value, [40:32] found_position, [49:41] list_length, rest zero
  output logic      [M_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic      [M_TUSER_W-1:0] m_tuser
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int IW   = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [IW-1:0]       idx;
  logic [CMD_W-1:0]    cmd;
  logic [POS_W-1:0]    pos;
  logic [DATA_W-1:0]   val;
  logic                clr;
  logic                found;
  logic                pend;
  logic [DATA_W-1:0]   prev;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   rval;
  logic [POS_W-1:0]    fpos;

  logic [DATA_W-1:0] head;
  cell_ctrl_t        ctrl;
  logic [CMPW-1:0]   pos_w;
  logic [CMPW-1:0]   cnt_w;
  logic [CMPW-1:0]   idx_w;
  logic              out_free;

  assign pos_w    = CMPW'(pos);
  assign cnt_w    = CMPW'(count);
  assign idx_w    = CMPW'(idx);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    ctrl.slot = IDX_W'(pos) - IDX_W'(1);
    case (state)
      S_SCAN:  ctrl.op = OP_ROT;
      S_SHIFT: ctrl.op = (cmd == CMD_INSERT) ? OP_INS : OP_DEL;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  sle_chain #(
    .CAPACITY(CAPACITY)
  ) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .ins_value(val),
    .head     (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          if (clr) begin
            count <= '0;
          end else begin
            case (cmd)
              CMD_INSERT: begin
                if (pos_w != '0 && pos_w <= cnt_w + CMPW'(1) && cnt_w != CMPW'(CAPACITY)) begin
                  state <= S_SHIFT;
                end
              end
              CMD_DELETE, CMD_GET: begin
                if (pos_w != '0 && pos_w <= cnt_w) begin
                  state <= S_SCAN;
                end
              end
              CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx == IW'(CAPACITY - 1)) begin
            state <= (cmd == CMD_DELETE) ? S_SHIFT : S_DONE;
          end
        end
        S_SHIFT: begin
          state <= S_DONE;
          if (cmd == CMD_INSERT) begin
            count <= count + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd <= s_tuser[2:0];
          clr <= s_tuser[3];
          pos <= s_tdata[8:0];
          val <= s_tdata[40:9];
        end
      end
      S_DECODE: begin
        status <= ST_OK;
        rval   <= '0;
        fpos   <= '0;
        found  <= 1'b0;
        pend   <= 1'b0;
        idx    <= '0;
        if (!clr) begin
          case (cmd)
            CMD_INSERT: begin
              if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                status <= ST_BADPOS;
              end else if (cnt_w == CMPW'(CAPACITY)) begin
                status <= ST_FULL;
              end
            end
            CMD_DELETE, CMD_GET: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                status <= ST_BADPOS;
              end
            end
            CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
              status <= ST_NOTFOUND;
            end
            default: begin
              status <= ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        prev <= head;
        idx  <= idx + IW'(1);
        case (cmd)
          CMD_DELETE, CMD_GET: begin
            if (idx_w == pos_w - CMPW'(1)) begin
              rval <= head;
            end
          end
          CMD_LOCATE: begin
            if (!found && idx_w < cnt_w && head == val) begin
              found  <= 1'b1;
              status <= ST_OK;
              fpos   <= POS_W'(idx_w + CMPW'(1));
            end
          end
          CMD_PRED: begin
            if (!found && idx != '0 && idx_w < cnt_w && head == val) begin
              found  <= 1'b1;
              status <= ST_OK;
              rval   <= prev;
            end
          end
          CMD_SUCC: begin
            if (pend && !found) begin
              found  <= 1'b1;
              status <= ST_OK;
              rval   <= head;
            end
            if (!pend && idx_w + CMPW'(1) < cnt_w && head == val) begin
              pend <= 1'b1;
            end
          end
          default: begin
            found <= found;
          end
        endcase
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {(M_TDATA_W - DATA_W - 2 * POS_W)'(0), POS_W'(count), fpos, rval};
      m_tuser <= status;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sle_checker.sv
// Port-level checker for the sequential list engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sequential_list_engine_assert.svh"

module sle_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [M_TUSER_W-1:0] m_tuser
);

  `SLE_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (!m_tvalid && s_tready), "reset left a word pending or input blocked")
  `SLE_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second command taken while one in progress")
  `SLE_ASSERT(a_length_bound, clk, rst, m_tvalid |-> (m_tdata[49:41] <= CAPACITY), "list length beyond capacity")
  `SLE_ASSERT(a_error_zero, clk, rst, (m_tvalid && (m_tuser == ST_BADPOS || m_tuser == ST_FULL)) |-> (m_tdata[40:0] == '0), "rejected command returned data")
  `SLE_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "output word changed while stalled")

endmodule

bind sequential_list_engine sle_checker #(
  .CAPACITY(CAPACITY)
) u_sle_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking stream testbench for the sequential list engine
`timescale 1ns / 1ps

module tb_top;
  import sle_pkg::*;

  localparam int CAP         = DEFAULT_CAPACITY;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 600;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic [POS_W-1:0]    found;
    logic [POS_W-1:0]    length;
  } reply_t;

  // shadow of the list, plus the replies owed by the block in order
  class list_tracker;
    logic [DATA_W-1:0] cells [CAP];
    int                length;
    reply_t            owed [$];
    int                errors;

    function new();
      length = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val, logic clr);
      reply_t r;
      int     p;
      int     k;
      bit     hit;
      r   = '0;
      p   = int'(pos);
      hit = 1'b0;
      if (clr) begin
        length = 0;
      end else if (op == CMD_INSERT) begin
        if (p < 1 || p > length + 1) begin
          r.status = ST_BADPOS;
        end else if (length >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (k = length; k >= p; k--) cells[k] = cells[k-1];
          cells[p-1] = val;
          length++;
        end
      end else if (op == CMD_DELETE || op == CMD_GET) begin
        if (p < 1 || p > length) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = cells[p-1];
          if (op == CMD_DELETE) begin
            for (k = p; k < length; k++) cells[k-1] = cells[k];
            length--;
          end
        end
      end else if (op == CMD_LOCATE) begin
        for (k = 0; k < length && !hit; k++) begin
          if (cells[k] == val) begin
            hit     = 1'b1;
            r.found = POS_W'(k + 1);
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end else if (op == CMD_PRED) begin
        for (k = 1; k < length && !hit; k++) begin
          if (cells[k] == val) begin
            hit     = 1'b1;
            r.value = cells[k-1];
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end else if (op == CMD_SUCC) begin
        for (k = 0; k + 1 < length && !hit; k++) begin
          if (cells[k] == val) begin
            hit     = 1'b1;
            r.value = cells[k+1];
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      r.length = POS_W'(length);
      owed.push_back(r);
    endfunction

    function void compare(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0h", $time, got);
        return;
      end
      want = owed.pop_front();
      compare("status", DATA_W'(want.status), DATA_W'(got.status));
      compare("result_value", want.value, got.value);
      compare("found_position", DATA_W'(want.found), DATA_W'(got.found));
      compare("list_length", DATA_W'(want.length), DATA_W'(got.length));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  list_tracker tracker = new();
  bit          quiet = 0;
  bit          long_hold = 0;
  int          stall_cycles = 0;

  sequential_list_engine #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_reply('{m_tuser[1:0], m_tdata[31:0], m_tdata[40:32], m_tdata[49:41]});
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                      logic [DATA_W-1:0] val, logic clr);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, val, pos};
    s_tuser  <= {clr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_command(op, pos, val, clr);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_pos(int top);
    if (top > 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(1, top));
    return POS_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(bit search);
    int r;
    r = $urandom_range(0, 99);
    if (search && tracker.length > 0 && r < 65)
      return tracker.cells[$urandom_range(0, tracker.length - 1)];
    if (r < (search ? 85 : 50)) begin
      case ($urandom_range(0, 7))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'hffff_fffe;
        4: return 32'd0;
        5: return 32'd1;
        6: return 32'd2;
        default: return 32'd3;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(int n, int ins_pct, int del_pct, int clr_pct);
    int                r;
    int                q;
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              clr;
    repeat (n) begin
      r   = $urandom_range(0, 99);
      clr = 1'b0;
      if (r < clr_pct) begin
        clr = 1'b1;
        op  = CMD_W'($urandom);
        pos = POS_W'($urandom);
        val = $urandom;
      end else if (r < clr_pct + ins_pct) begin
        op  = CMD_INSERT;
        pos = pick_pos(tracker.length + 1);
        val = pick_value(0);
      end else if (r < clr_pct + ins_pct + del_pct) begin
        op  = CMD_DELETE;
        pos = pick_pos(tracker.length);
        val = $urandom;
      end else begin
        q = $urandom_range(0, 19);
        if (q < 6)       op = CMD_GET;
        else if (q < 11) op = CMD_LOCATE;
        else if (q < 15) op = CMD_PRED;
        else if (q < 19) op = CMD_SUCC;
        else             op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        pos = pick_pos(tracker.length);
        val = pick_value(1);
      end
      send(op, pos, val, clr);
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty-list errors, edges of the value range, neighbour searches, unused codes, clear
    send(CMD_GET,    9'd1,   32'd0,        1'b0);
    send(CMD_DELETE, 9'd0,   32'd0,        1'b0);
    send(CMD_INSERT, 9'd0,   32'd5,        1'b0);
    send(CMD_INSERT, 9'd2,   32'd5,        1'b0);
    send(CMD_INSERT, 9'd1,   32'h8000_0000, 1'b0);
    send(CMD_INSERT, 9'd2,   32'h7fff_ffff, 1'b0);
    send(CMD_INSERT, 9'd1,   32'hffff_ffff, 1'b0);
    send(CMD_INSERT, 9'd2,   32'd0,        1'b0);
    send(CMD_GET,    9'd4,   32'd0,        1'b0);
    send(CMD_GET,    9'd5,   32'd0,        1'b0);
    send(CMD_LOCATE, 9'd0,   32'h7fff_ffff, 1'b0);
    send(CMD_LOCATE, 9'd0,   32'd5,        1'b0);
    send(CMD_PRED,   9'd0,   32'hffff_ffff, 1'b0);
    send(CMD_PRED,   9'd0,   32'd0,        1'b0);
    send(CMD_SUCC,   9'd0,   32'h7fff_ffff, 1'b0);
    send(CMD_SUCC,   9'd0,   32'hffff_ffff, 1'b0);
    send(CMD_SPARE_LO, 9'h1ff, 32'hffff_ffff, 1'b0);
    send(CMD_SPARE_HI, 9'd3, 32'h1234_5678, 1'b0);
    send(CMD_DELETE, 9'd2,   32'd0,        1'b0);
    send(CMD_DELETE, 9'd3,   32'd0,        1'b0);
    send(CMD_INSERT, 9'h1ff, 32'd7,        1'b0);
    send(CMD_INSERT, 9'd256, 32'hdead_beef, 1'b1);
    send(CMD_GET,    9'd1,   32'd0,        1'b0);
    send(CMD_DELETE, 9'd1,   32'd0,        1'b0);
    drain();

    // fill past capacity, churn while the result side stalls, then delete, clear and run without back-pressure
    run_phase(420, 85, 5, 0);
    long_hold = 1;
    run_phase(250, 45, 40, 0);
    drain();
    run_phase(400, 10, 70, 0);
    run_phase(250, 40, 30, 2);
    quiet = 1;
    run_phase(200, 45, 35, 1);

    drain();
    repeat (CAP + 10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
